[design/lic_pkg.sv]
// Shared widths, result codes and the divider cell record for the line intersection block.
package lic_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * COORD_W + 1;
    localparam int C_W     = 2 * COORD_W + 2;
    localparam int DET_W   = 2 * COORD_W + 3;
    localparam int NUM_W   = 3 * COORD_W + 3;
    localparam int OUT_W   = 32;

    localparam logic [1:0] OUTCOME_HIT      = 2'd0;
    localparam logic [1:0] OUTCOME_PARALLEL = 2'd1;
    localparam logic [1:0] OUTCOME_SAT      = 2'd2;

    typedef struct packed {
        logic             parallel;
        logic             neg_x;
        logic             neg_y;
        logic [DET_W-1:0] den;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        logic [DET_W:0]   rem_x;
        logic [DET_W:0]   rem_y;
        logic [NUM_W-1:0] quo_x;
        logic [NUM_W-1:0] quo_y;
    } lic_cell_t;

endpackage

[design/lic_front.sv]
// Front end: line coefficients, determinant and Cramer numerators over six stages.
module lic_front
    import lic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [8*COORD_W-1:0] in_data,
    output logic                out_valid,
    output lic_cell_t           out_cell
);

    logic [5:0] valid_reg;

    logic signed [COORD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;

    logic signed [DIFF_W-1:0]  a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [COORD_W-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;

    logic signed [PROD_W-1:0]  pa1_reg, pb1_reg, pa2_reg, pb2_reg;
    logic signed [C_W-1:0]     d1_reg, d2_reg;
    logic signed [DIFF_W-1:0]  a1s2_reg, b1s2_reg, a2s2_reg, b2s2_reg;

    logic signed [C_W-1:0]     c1_reg, c2_reg;
    logic signed [DET_W-1:0]   det3_reg;
    logic signed [DIFF_W-1:0]  a1s3_reg, b1s3_reg, a2s3_reg, b2s3_reg;

    logic signed [NUM_W-1:0]   m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DET_W-1:0]   det4_reg;

    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic signed [DET_W-1:0]   det5_reg;

    lic_cell_t cell_reg, cell_next;

    assign ax1 = in_data[0*COORD_W +: COORD_W];
    assign ay1 = in_data[1*COORD_W +: COORD_W];
    assign ax2 = in_data[2*COORD_W +: COORD_W];
    assign ay2 = in_data[3*COORD_W +: COORD_W];
    assign bx1 = in_data[4*COORD_W +: COORD_W];
    assign by1 = in_data[5*COORD_W +: COORD_W];
    assign bx2 = in_data[6*COORD_W +: COORD_W];
    assign by2 = in_data[7*COORD_W +: COORD_W];

    always_comb
    begin
        cell_next          = '0;
        cell_next.parallel = (det5_reg == '0);
        cell_next.neg_x    = nx_reg[NUM_W-1] ^ det5_reg[DET_W-1];
        cell_next.neg_y    = ny_reg[NUM_W-1] ^ det5_reg[DET_W-1];
        cell_next.den      = det5_reg[DET_W-1] ? DET_W'(-det5_reg) : DET_W'(det5_reg);
        cell_next.num_x    = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        cell_next.num_y    = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= {ay2[COORD_W-1], ay2} - {ay1[COORD_W-1], ay1};
            b1_reg  <= {ax1[COORD_W-1], ax1} - {ax2[COORD_W-1], ax2};
            a2_reg  <= {by2[COORD_W-1], by2} - {by1[COORD_W-1], by1};
            b2_reg  <= {bx1[COORD_W-1], bx1} - {bx2[COORD_W-1], bx2};
            ax1_reg <= ax1;
            ay1_reg <= ay1;
            bx1_reg <= bx1;
            by1_reg <= by1;

            pa1_reg  <= a1_reg * ax1_reg;
            pb1_reg  <= b1_reg * ay1_reg;
            pa2_reg  <= a2_reg * bx1_reg;
            pb2_reg  <= b2_reg * by1_reg;
            d1_reg   <= a1_reg * b2_reg;
            d2_reg   <= b1_reg * a2_reg;
            a1s2_reg <= a1_reg;
            b1s2_reg <= b1_reg;
            a2s2_reg <= a2_reg;
            b2s2_reg <= b2_reg;

            c1_reg   <= {pa1_reg[PROD_W-1], pa1_reg} + {pb1_reg[PROD_W-1], pb1_reg};
            c2_reg   <= {pa2_reg[PROD_W-1], pa2_reg} + {pb2_reg[PROD_W-1], pb2_reg};
            det3_reg <= {d1_reg[C_W-1], d1_reg} - {d2_reg[C_W-1], d2_reg};
            a1s3_reg <= a1s2_reg;
            b1s3_reg <= b1s2_reg;
            a2s3_reg <= a2s2_reg;
            b2s3_reg <= b2s2_reg;

            m1_reg   <= c1_reg * b2s3_reg;
            m2_reg   <= b1s3_reg * c2_reg;
            m3_reg   <= a1s3_reg * c2_reg;
            m4_reg   <= c1_reg * a2s3_reg;
            det4_reg <= det3_reg;

            nx_reg   <= m1_reg - m2_reg;
            ny_reg   <= m3_reg - m4_reg;
            det5_reg <= det4_reg;

            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_cell  = cell_reg;

endmodule

[design/lic_div_cell.sv]
// One restoring division cell that resolves one quotient bit for both coordinates.
module lic_div_cell
    import lic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  lic_cell_t in_cell,
    output logic      out_valid,
    output lic_cell_t out_cell
);

    logic      valid_reg;
    lic_cell_t cell_reg, cell_next;
    logic [DET_W:0] trial_x, trial_y, den_ext;
    logic           bit_x, bit_y;

    always_comb
    begin
        den_ext   = {1'b0, in_cell.den};
        trial_x   = {in_cell.rem_x[DET_W-1:0], in_cell.num_x[NUM_W-1]};
        trial_y   = {in_cell.rem_y[DET_W-1:0], in_cell.num_y[NUM_W-1]};
        bit_x     = (trial_x >= den_ext);
        bit_y     = (trial_y >= den_ext);
        cell_next = in_cell;
        cell_next.rem_x = bit_x ? trial_x - den_ext : trial_x;
        cell_next.rem_y = bit_y ? trial_y - den_ext : trial_y;
        cell_next.num_x = {in_cell.num_x[NUM_W-2:0], 1'b0};
        cell_next.num_y = {in_cell.num_y[NUM_W-2:0], 1'b0};
        cell_next.quo_x = {in_cell.quo_x[NUM_W-2:0], bit_x};
        cell_next.quo_y = {in_cell.quo_y[NUM_W-2:0], bit_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

[design/line_intersection_cramer.sv]
// Top level of the two-line intersection block using Cramer's rule.
// The pipeline has six front-end stages, 51 divider cells and one output register.
// Throughput is one transaction per cycle; the whole pipeline halts while the output waits.
// The divider is a chain of cells, each resolving one quotient bit for both coordinates.
// Reset is asynchronous and active low and clears only the valid flags.
module line_intersection_cramer
    import lic_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // line_a_start_x, line_a_start_y, line_a_end_x, line_a_end_y,
    // line_b_start_x, line_b_start_y, line_b_end_x, line_b_end_y
    input  logic [8*COORD_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cross_x, cross_y
    output logic [2*OUT_W-1:0]    m_tdata,
    // outcome
    output logic [1:0]            m_tuser
);

    localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'(33'h0_7FFF_FFFF);
    localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(33'h0_8000_0000);

    logic en;
    logic      valid_chain [0:NUM_W];
    lic_cell_t cell_chain  [0:NUM_W];

    logic              out_valid_reg;
    logic [OUT_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [1:0]        outcome_reg, outcome_next;
    logic              sat_x, sat_y;
    lic_cell_t         fin;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    lic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (valid_chain[0]),
        .out_cell  (cell_chain[0])
    );

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        lic_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_cell   (cell_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_cell  (cell_chain[i+1])
        );
    end

    assign fin = cell_chain[NUM_W];

    always_comb
    begin
        sat_x = fin.neg_x ? (fin.quo_x > NEG_LIMIT) : (fin.quo_x > POS_LIMIT);
        sat_y = fin.neg_y ? (fin.quo_y > NEG_LIMIT) : (fin.quo_y > POS_LIMIT);
        if (sat_x)
            x_next = fin.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            x_next = fin.neg_x ? OUT_W'(-fin.quo_x) : OUT_W'(fin.quo_x);
        if (sat_y)
            y_next = fin.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            y_next = fin.neg_y ? OUT_W'(-fin.quo_y) : OUT_W'(fin.quo_y);
        outcome_next = (sat_x || sat_y) ? OUTCOME_SAT : OUTCOME_HIT;
        if (fin.parallel)
        begin
            x_next       = '0;
            y_next       = '0;
            outcome_next = OUTCOME_PARALLEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_chain[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            outcome_reg <= outcome_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {y_reg, x_reg};
    assign m_tuser  = outcome_reg;

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output register state");

    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == OUTCOME_PARALLEL) |-> (m_tdata == '0))
        else $error("parallel result carries a nonzero point");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == OUTCOME_SAT) |->
        (x_reg == 32'h7FFF_FFFF || x_reg == 32'h8000_0000 ||
         y_reg == 32'h7FFF_FFFF || y_reg == 32'h8000_0000))
        else $error("saturated result has no coordinate at a limit");

endmodule

[bench/tb_line_intersection_cramer.sv]
// Testbench for the line intersection block: directed and random line pairs checked against a predictor.
`timescale 1ns / 1ps

module tb_line_intersection_cramer;
    import lic_pkg::*;

    typedef struct {
        logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    } pair_t;

    typedef struct {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [1:0]  outcome;
    } cross_t;

    localparam int LATENCY = 58;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [8*COORD_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [2*OUT_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    cross_t expected_crossings[$];
    int fail_count;
    int cycle_count;
    int hold_off_cycles;
    bit random_stall;

    line_intersection_cramer u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] clamp32(input logic signed [127:0] q, inout bit sat);
        if (q > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (q < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    function automatic cross_t solve_crossing(input pair_t p);
        logic signed [127:0] a1, b1, a2, b2, c1, c2, det, nx, ny;
        cross_t r;
        bit sat;
        a1 = p.ay2 - p.ay1;
        b1 = p.ax1 - p.ax2;
        a2 = p.by2 - p.by1;
        b2 = p.bx1 - p.bx2;
        c1 = a1 * p.ax1 + b1 * p.ay1;
        c2 = a2 * p.bx1 + b2 * p.by1;
        det = a1 * b2 - b1 * a2;
        sat = 1'b0;
        if (det == 0) begin
            r.cx = '0;
            r.cy = '0;
            r.outcome = OUTCOME_PARALLEL;
        end
        else begin
            nx = c1 * b2 - b1 * c2;
            ny = a1 * c2 - c1 * a2;
            r.cx = clamp32(nx / det, sat);
            r.cy = clamp32(ny / det, sat);
            r.outcome = sat ? OUTCOME_SAT : OUTCOME_HIT;
        end
        return r;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_pair(input pair_t p, input bit with_gaps);
        int gap;
        gap = with_gaps ? gap_length() : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {p.by2, p.bx2, p.by1, p.bx1, p.ay2, p.ax2, p.ay1, p.ax1};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_crossings.push_back(solve_crossing(p));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_crossings.size() != 0) @(negedge clk);
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        p.ax1 = 16'($urandom); p.ay1 = 16'($urandom);
        p.ax2 = 16'($urandom); p.ay2 = 16'($urandom);
        p.bx1 = 16'($urandom); p.by1 = 16'($urandom);
        p.bx2 = 16'($urandom); p.by2 = 16'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                p.ax1 = 16'($urandom_range(0, 511) - 256);
                p.ay1 = 16'($urandom_range(0, 511) - 256);
                p.ax2 = 16'(p.ax1 + $urandom_range(1, 9));
                p.ay2 = 16'(p.ay1 + $urandom_range(0, 9));
                p.bx1 = 16'($urandom_range(0, 511) - 256);
                p.by1 = 16'($urandom_range(0, 511) - 256);
                p.bx2 = 16'(p.bx1 + $urandom_range(0, 9));
                p.by2 = 16'(p.by1 - $urandom_range(1, 9));
            end
            1: begin
                p.bx2 = 16'(p.bx1 + (p.ax2 - p.ax1));
                p.by2 = 16'(p.by1 + (p.ay2 - p.ay1));
            end
            2: begin
                p.ax2 = p.ax1;
                p.ay2 = p.ay1;
            end
            3: begin
                p.ax2 = 16'(p.ax1 + $urandom_range(1, 3));
                p.ay2 = 16'(p.ay1 + $urandom_range(0, 3));
                p.bx2 = 16'(p.bx1 + (p.ax2 - p.ax1));
                p.by2 = 16'(p.by1 + (p.ay2 - p.ay1) + 16'sd1);
            end
            4: begin
                p.ax1 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                p.by2 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_directed();
        pair_t p;
        p = '{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100,
              16'sh0000, 16'sh0100, 16'sh0100, 16'sh0000};
        send_pair(p, 1'b0);
        p = '{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0000,
              16'sh0000, 16'sh0100, 16'sh0100, 16'sh0100};
        send_pair(p, 1'b0);
        p = '{16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100,
              16'sh0200, 16'sh0200, 16'sh0300, 16'sh0300};
        send_pair(p, 1'b0);
        p = '{16'sh0040, 16'sh0040, 16'sh0040, 16'sh0040,
              16'sh0000, 16'sh0100, 16'sh0100, 16'sh0000};
        send_pair(p, 1'b0);
        p = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        send_pair(p, 1'b0);
        p = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
        send_pair(p, 1'b0);
        p = '{16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0001,
              16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000};
        send_pair(p, 1'b0);
        p = '{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0003,
              16'sh0000, 16'sh0001, 16'sh0001, 16'sh0004};
        send_pair(p, 1'b0);
        p = '{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000,
              16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001};
        send_pair(p, 1'b0);
        p = '{16'sh0000, 16'sh7fff, 16'sh0001, 16'sh7fff,
              16'sh0000, 16'sh8000, 16'sh0001, 16'sh8001};
        send_pair(p, 1'b0);
        p = '{16'sh0000, 16'sh0000, 16'sh0003, 16'sh0001,
              16'sh0000, 16'sh0000, 16'sh0001, 16'shfffe};
        send_pair(p, 1'b0);
        p = '{16'shffff, 16'shffff, 16'shffff, 16'shffff,
              16'shffff, 16'shffff, 16'shffff, 16'shffff};
        send_pair(p, 1'b0);
        p = '{16'sh0100, 16'sh0000, 16'shff00, 16'sh0000,
              16'sh0000, 16'shff00, 16'sh0000, 16'sh0100};
        send_pair(p, 1'b0);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_pair(random_pair(), 1'b1);
    endtask

    task automatic test_back_to_back(input int count);
        repeat (count) send_pair(random_pair(), 1'b0);
    endtask

    task automatic test_output_hold_off();
        random_stall = 1'b0;
        hold_off_cycles = 200;
        repeat (120) send_pair(random_pair(), 1'b0);
        wait_drained();
        random_stall = 1'b1;
    endtask

    always @(negedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (!random_stall)
            m_tready <= 1'b1;
        else if ($urandom_range(0, 99) == 0) begin
            hold_off_cycles <= $urandom_range(10, 60);
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk) begin
        cross_t exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_crossings.size() == 0) begin
                $error("unexpected result x=%h y=%h outcome=%0d",
                       m_tdata[31:0], m_tdata[63:32], m_tuser);
                fail_count++;
            end
            else begin
                exp_r = expected_crossings.pop_front();
                if (m_tdata[31:0] !== exp_r.cx) begin
                    $error("cross_x expected %h actual %h", exp_r.cx, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== exp_r.cy) begin
                    $error("cross_y expected %h actual %h", exp_r.cy, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tuser !== exp_r.outcome) begin
                    $error("outcome expected %0d actual %0d", exp_r.outcome, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_line_intersection_cramer failed");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        random_stall = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(700);
        wait_drained();
        test_output_hold_off();
        test_back_to_back(300);
        test_random(800);
        wait_drained();
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0)
            $display("tb_line_intersection_cramer passed");
        else
            $display("tb_line_intersection_cramer failed");
        $finish;
    end
endmodule
